// ----- hdl/crb_pkg.sv -----
`timescale 1ns / 1ps
package crb_pkg;

  localparam int DEF_SCREEN_W    = 320;
  localparam int DEF_SCREEN_H    = 200;
  localparam int DEF_NUM_BUFFERS = 5;

  // signed width for the clipping arithmetic; covers 16-bit inputs and screens up to 1024
  localparam int CLIP_W = 20;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_COPY  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DROP = 2'd1,
    ST_OFF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PIX_ADDR,
    S_PIX_MEM,
    S_PIX_WAIT,
    S_CLIP_SRC,
    S_CLIP_DST,
    S_LIM_SRC,
    S_LIM_DST,
    S_CHECK,
    S_ADDR_MUL,
    S_ADDR_SUM,
    S_PX_RD,
    S_PX_WR
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clr_step;
    logic    addr_mul;
    logic    pix_wr;
    logic    pix_rd;
    logic    clip_src;
    logic    clip_dst;
    logic    lim_src;
    logic    lim_dst;
    logic    addr_sum;
    logic    px_rd;
    logic    px_wr;
    logic    finish;
    status_t fin_status;
    logic    fin_rdata;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    clr_last;
    logic    pix_off;
    logic    fail;
    logic    empty;
    logic    col_last;
    logic    row_last;
  } stat_t;

endpackage

// ----- hdl/crb_ram.sv -----
`timescale 1ns / 1ps
module crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

// ----- hdl/crb_ctrl.sv -----
`timescale 1ns / 1ps
module crb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output crb_pkg::cmd_t cmd,
  input  crb_pkg::stat_t stat
);
  import crb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.act inside {ACT_WRITE, ACT_READ}) begin
          state_nxt = S_PIX_ADDR;
        end else if (stat.act == ACT_COPY) begin
          state_nxt = S_CLIP_SRC;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end
      end
      S_PIX_ADDR: begin
        cmd.addr_mul = 1'b1;
        if (stat.pix_off) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OFF;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_PIX_MEM;
        end
      end
      S_PIX_MEM: begin
        if (stat.act == ACT_WRITE) begin
          cmd.pix_wr     = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.pix_rd = 1'b1;
          state_nxt  = S_PIX_WAIT;
        end
      end
      S_PIX_WAIT: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_DONE;
        cmd.fin_rdata  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_CLIP_SRC: begin
        cmd.clip_src = 1'b1;
        state_nxt    = S_CLIP_DST;
      end
      S_CLIP_DST: begin
        cmd.clip_dst = 1'b1;
        state_nxt    = S_LIM_SRC;
      end
      S_LIM_SRC: begin
        cmd.lim_src = 1'b1;
        state_nxt   = S_LIM_DST;
      end
      S_LIM_DST: begin
        cmd.lim_dst = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (stat.fail) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DROP;
          state_nxt      = S_IDLE;
        end else if (stat.empty) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_ADDR_MUL;
        end
      end
      S_ADDR_MUL: begin
        cmd.addr_mul = 1'b1;
        state_nxt    = S_ADDR_SUM;
      end
      S_ADDR_SUM: begin
        cmd.addr_sum = 1'b1;
        state_nxt    = S_PX_RD;
      end
      S_PX_RD: begin
        cmd.px_rd = 1'b1;
        state_nxt = S_PX_WR;
      end
      S_PX_WR: begin
        cmd.px_wr = 1'b1;
        if (stat.col_last && stat.row_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_PX_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/crb_datapath.sv -----
`timescale 1ns / 1ps
module crb_datapath #(
  parameter int SCREEN_W    = crb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H    = crb_pkg::DEF_SCREEN_H,
  parameter int NUM_BUFFERS = crb_pkg::DEF_NUM_BUFFERS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  crb_pkg::cmd_t      cmd,
  output crb_pkg::stat_t     stat,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_src_buffer,
  input  logic signed [15:0] in_src_x,
  input  logic signed [15:0] in_src_y,
  input  logic [2:0]         in_dst_buffer,
  input  logic signed [15:0] in_dst_x,
  input  logic signed [15:0] in_dst_y,
  input  logic signed [15:0] in_copy_width,
  input  logic signed [15:0] in_copy_height,
  input  logic               in_skip_zero,
  input  logic [7:0]         in_pixel_value,
  output logic               out_valid,
  output logic [7:0]         out_read_data,
  output logic [1:0]         out_status
);
  import crb_pkg::*;

  localparam int PLANE = SCREEN_W * SCREEN_H;
  localparam int DEPTH = NUM_BUFFERS * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_W);
  localparam int YW    = $clog2(SCREEN_H);

  localparam logic signed [CLIP_W-1:0] SW   = CLIP_W'(SCREEN_W);
  localparam logic signed [CLIP_W-1:0] SH   = CLIP_W'(SCREEN_H);
  localparam logic signed [CLIP_W-1:0] ZERO = '0;
  localparam logic [3:0]               NB   = 4'(NUM_BUFFERS);

  action_t                   act_r;
  logic [2:0]                sb_r, db_r;
  logic                      key_r;
  logic [7:0]                pv_r;
  logic signed [CLIP_W-1:0]  xs_r, ys_r, xd_r, yd_r, w_r, h_r;
  logic signed [CLIP_W-1:0]  xs_nxt, ys_nxt, xd_nxt, yd_nxt, w_nxt, h_nxt;
  logic                      drop_r, drop_nxt;

  logic [AW-1:0]             sprod_r, dprod_r, sbase_r, dbase_r;
  logic [AW-1:0]             s_row_r, d_row_r;
  logic [XW-1:0]             col_r;
  logic [YW-1:0]             row_r;
  logic                      back_r;
  logic [AW-1:0]             clr_r;

  logic                      out_valid_r;
  logic [7:0]                out_read_data_r;
  status_t                   out_status_r;

  logic [AW-1:0]             s_start, d_start, s_addr, d_addr;
  logic [XW-1:0]             w_m1;
  logic [YW-1:0]             h_m1;
  logic                      src_ok, dst_ok, go_back, col_last, row_last;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [7:0]                ram_wdata, rd_data;

  // ---------------- item capture and clipping ----------------
  always_comb begin
    xs_nxt   = xs_r;
    ys_nxt   = ys_r;
    xd_nxt   = xd_r;
    yd_nxt   = yd_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    drop_nxt = drop_r;
    if (cmd.load) begin
      xs_nxt   = CLIP_W'(in_src_x);
      ys_nxt   = CLIP_W'(in_src_y);
      xd_nxt   = CLIP_W'(in_dst_x);
      yd_nxt   = CLIP_W'(in_dst_y);
      w_nxt    = CLIP_W'(in_copy_width);
      h_nxt    = CLIP_W'(in_copy_height);
      drop_nxt = 1'b0;
    end
    if (cmd.clip_src) begin
      if (xs_r >= SW) begin
        drop_nxt = 1'b1;
      end else if (xs_r < ZERO) begin
        xd_nxt = xd_r - xs_r;
        w_nxt  = w_r + xs_r;
        xs_nxt = ZERO;
      end
      if (ys_r >= SH) begin
        drop_nxt = 1'b1;
      end else if (ys_r < ZERO) begin
        yd_nxt = yd_r - ys_r;
        h_nxt  = h_r + ys_r;
        ys_nxt = ZERO;
      end
    end
    if (cmd.clip_dst) begin
      if (xd_r >= SW) begin
        drop_nxt = 1'b1;
      end else if (xd_r < ZERO) begin
        xs_nxt = xs_r - xd_r;
        w_nxt  = w_r + xd_r;
        xd_nxt = ZERO;
      end
      if (yd_r >= SH) begin
        drop_nxt = 1'b1;
      end else if (yd_r < ZERO) begin
        ys_nxt = ys_r - yd_r;
        h_nxt  = h_r + yd_r;
        yd_nxt = ZERO;
      end
    end
    if (cmd.lim_src) begin
      if (SW - xs_r - w_r < ZERO) w_nxt = SW - xs_r;
      if (SH - ys_r - h_r < ZERO) h_nxt = SH - ys_r;
    end
    if (cmd.lim_dst) begin
      if (SW - xd_r - w_r < ZERO) w_nxt = SW - xd_r;
      if (SH - yd_r - h_r < ZERO) h_nxt = SH - yd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_action);
      sb_r  <= in_src_buffer;
      db_r  <= in_dst_buffer;
      key_r <= in_skip_zero;
      pv_r  <= in_pixel_value;
    end
    xs_r   <= xs_nxt;
    ys_r   <= ys_nxt;
    xd_r   <= xd_nxt;
    yd_r   <= yd_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    drop_r <= drop_nxt;
  end

  assign src_ok = ({1'b0, sb_r} < NB);
  assign dst_ok = ({1'b0, db_r} < NB);

  // ---------------- addressing ----------------
  assign s_start = sbase_r + sprod_r + AW'(xs_r[XW-1:0]);
  assign d_start = dbase_r + dprod_r + AW'(xd_r[XW-1:0]);
  assign s_addr  = s_row_r + AW'(col_r);
  assign d_addr  = d_row_r + AW'(col_r);
  assign w_m1    = w_r[XW-1:0] - XW'(1);
  assign h_m1    = h_r[YW-1:0] - YW'(1);
  // unkeyed copies whose destination starts above the source copy right to left
  assign go_back = (d_start > s_start) && !key_r;

  assign col_last = back_r ? (col_r == '0) : (col_r == w_m1);
  assign row_last = (row_r == h_m1);

  always_ff @(posedge clk) begin
    if (cmd.addr_mul) begin
      sprod_r <= AW'(ys_r[YW-1:0]) * AW'(SCREEN_W);
      dprod_r <= AW'(yd_r[YW-1:0]) * AW'(SCREEN_W);
      sbase_r <= AW'(sb_r) * AW'(PLANE);
      dbase_r <= AW'(db_r) * AW'(PLANE);
    end
    if (cmd.addr_sum) begin
      s_row_r <= s_start;
      d_row_r <= d_start;
      back_r  <= go_back;
      col_r   <= go_back ? w_m1 : '0;
      row_r   <= '0;
    end else if (cmd.px_wr) begin
      if (col_last) begin
        col_r <= back_r ? w_m1 : '0;
        if (!row_last) begin
          row_r   <= row_r + YW'(1);
          s_row_r <= s_row_r + AW'(SCREEN_W);
          d_row_r <= d_row_r + AW'(SCREEN_W);
        end
      end else begin
        col_r <= back_r ? (col_r - XW'(1)) : (col_r + XW'(1));
      end
    end
  end

  // clearing pass sweeps the whole store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // ---------------- frame store ----------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = d_addr;
    ram_wdata = rd_data;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (cmd.pix_wr) begin
      ram_we    = 1'b1;
      ram_waddr = d_start;
      ram_wdata = pv_r;
    end else if (cmd.px_wr) begin
      ram_we = !key_r || (rd_data != 8'h00);
    end
  end

  assign ram_re    = cmd.pix_rd | cmd.px_rd;
  assign ram_raddr = cmd.pix_rd ? d_start : s_addr;

  crb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rd_data (rd_data)
  );

  // ---------------- result ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r    <= cmd.fin_status;
      out_read_data_r <= cmd.fin_rdata ? rd_data : 8'h00;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

  always_comb begin
    stat          = '0;
    stat.act      = act_r;
    stat.clr_last = (clr_r == AW'(DEPTH - 1));
    stat.pix_off  = !dst_ok || (xd_r < ZERO) || (xd_r >= SW) ||
                    (yd_r < ZERO) || (yd_r >= SH);
    stat.fail     = drop_r || !src_ok || !dst_ok ||
                    (xs_r < ZERO) || (xs_r >= SW) || (xd_r < ZERO) || (xd_r >= SW) ||
                    (ys_r < ZERO) || (ys_r >= SH) || (yd_r < ZERO) || (yd_r >= SH) ||
                    (w_r < ZERO) || (w_r >= SW) || (h_r < ZERO) || (h_r >= SH);
    stat.empty    = (w_r == ZERO) || (h_r == ZERO);
    stat.col_last = col_last;
    stat.row_last = row_last;
  end

endmodule

// ----- hdl/clipped_rect_blit_color_key.sv -----
`timescale 1ns / 1ps
// Frame buffer blitter: pixel write, pixel read and clipped rectangle copy over
// NUM_BUFFERS planes of SCREEN_W x SCREEN_H 8-bit pixels held in one single-port-write,
// registered-read memory. An item is taken when start is high and busy is low; exactly
// one result follows, shown for a single cycle with out_valid, and it cannot be held
// off, so it must be captured when it appears. After reset the block clears the whole
// store, one pixel a cycle, and stays busy until the last pixel is cleared. A copy dropped
// by clipping or of zero size ends without touching memory; a copy of w x h clipped pixels
// takes each pixel through a memory read and then a memory write. The result appears in
// the cycle busy falls.
module clipped_rect_blit_color_key #(
  parameter int SCREEN_W    = crb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H    = crb_pkg::DEF_SCREEN_H,
  parameter int NUM_BUFFERS = crb_pkg::DEF_NUM_BUFFERS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_src_buffer,
  input  logic signed [15:0] in_src_x,
  input  logic signed [15:0] in_src_y,
  input  logic [2:0]         in_dst_buffer,
  input  logic signed [15:0] in_dst_x,
  input  logic signed [15:0] in_dst_y,
  input  logic signed [15:0] in_copy_width,
  input  logic signed [15:0] in_copy_height,
  input  logic               in_skip_zero,
  input  logic [7:0]         in_pixel_value,
  output logic               out_valid,
  output logic [7:0]         out_read_data,
  output logic [1:0]         out_status
);
  import crb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  crb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  crb_datapath #(
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H),
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_src_buffer  (in_src_buffer),
    .in_src_x       (in_src_x),
    .in_src_y       (in_src_y),
    .in_dst_buffer  (in_dst_buffer),
    .in_dst_x       (in_dst_x),
    .in_dst_y       (in_dst_y),
    .in_copy_width  (in_copy_width),
    .in_copy_height (in_copy_height),
    .in_skip_zero   (in_skip_zero),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status)
  );

endmodule

// ----- hdl/crb_checker.sv -----
`timescale 1ns / 1ps
module crb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic [7:0] out_read_data,
  input logic [1:0] out_status
);
  import crb_pkg::*;

  // an accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an item was accepted");

  // the result arrives together with the return to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // read data is zero unless a pixel access completed normally
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_read_data == 8'h00))
    else $error("nonzero read data on a failed item");

  // the unused action goes busy through dispatch and then answers done with zero read data
  a_noop_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_NONE)) |=>
      busy ##1 (out_valid && (out_status == ST_DONE) && (out_read_data == 8'h00)))
    else $error("unused action did not complete as expected");

endmodule

bind clipped_rect_blit_color_key crb_checker u_crb_checker (.*);

// ----- tb/blit_checker.sv -----
`timescale 1ns / 1ps
module blit_checker
  import crb_pkg::*;
#(
  parameter int SCREEN_W    = DEF_SCREEN_W,
  parameter int SCREEN_H    = DEF_SCREEN_H,
  parameter int NUM_BUFFERS = DEF_NUM_BUFFERS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_src_buffer,
  input  logic signed [15:0] in_src_x,
  input  logic signed [15:0] in_src_y,
  input  logic [2:0]         in_dst_buffer,
  input  logic signed [15:0] in_dst_x,
  input  logic signed [15:0] in_dst_y,
  input  logic signed [15:0] in_copy_width,
  input  logic signed [15:0] in_copy_height,
  input  logic               in_skip_zero,
  input  logic [7:0]         in_pixel_value,
  input  logic               out_valid,
  input  logic [7:0]         out_read_data,
  input  logic [1:0]         out_status,
  output int                 errors,
  output int                 outstanding
);

  localparam int PLANE = SCREEN_W * SCREEN_H;

  typedef struct packed {
    logic [7:0] rdata;
    status_t    status;
  } pix_result_t;

  logic [7:0]  frame_mem [NUM_BUFFERS * PLANE];
  pix_result_t pending_results [$];
  int          results_seen;

  assign outstanding = pending_results.size();

  // the block clears every plane after reset
  initial begin
    errors       = 0;
    results_seen = 0;
    foreach (frame_mem[i]) frame_mem[i] = 8'd0;
  end

  function automatic int pix_addr(int b, int x, int y);
    return b * PLANE + y * SCREEN_W + x;
  endfunction

  function automatic status_t blit_rect(int sb, int sx, int sy, int db, int dx, int dy,
                                        int w, int h, bit key);
    logic [7:0] row_buf [SCREEN_W];
    int         s;
    int         d;
    int         r;
    int         i;
    if (sx >= SCREEN_W) return ST_DROP;
    if (sx < 0) begin
      dx -= sx; w += sx; sx = 0;
    end
    if (sy >= SCREEN_H) return ST_DROP;
    if (sy < 0) begin
      dy -= sy; h += sy; sy = 0;
    end
    if (dx >= SCREEN_W) return ST_DROP;
    if (dx < 0) begin
      sx -= dx; w += dx; dx = 0;
    end
    if (dy >= SCREEN_H) return ST_DROP;
    if (dy < 0) begin
      sy -= dy; h += dy; dy = 0;
    end
    if (SCREEN_W - sx - w < 0) w = SCREEN_W - sx;
    if (SCREEN_H - sy - h < 0) h = SCREEN_H - sy;
    if (SCREEN_W - dx - w < 0) w = SCREEN_W - dx;
    if (SCREEN_H - dy - h < 0) h = SCREEN_H - dy;
    if (sx < 0 || sx >= SCREEN_W || dx < 0 || dx >= SCREEN_W) return ST_DROP;
    if (sy < 0 || sy >= SCREEN_H || dy < 0 || dy >= SCREEN_H) return ST_DROP;
    // a full-width or full-height rectangle is rejected too
    if (w < 0 || w >= SCREEN_W || h < 0 || h >= SCREEN_H) return ST_DROP;
    if (sb >= NUM_BUFFERS || db >= NUM_BUFFERS) return ST_DROP;
    for (r = 0; r < h; r++) begin
      s = pix_addr(sb, sx, sy + r);
      d = pix_addr(db, dx, dy + r);
      if (key) begin
        // transparent copy reads memory as already updated
        for (i = 0; i < w; i++)
          if (frame_mem[s + i] != 8'd0) frame_mem[d + i] = frame_mem[s + i];
      end else begin
        // snapshot the source row so overlap behaves like memmove
        for (i = 0; i < w; i++) row_buf[i] = frame_mem[s + i];
        for (i = 0; i < w; i++) frame_mem[d + i] = row_buf[i];
      end
    end
    return ST_DONE;
  endfunction

  function automatic pix_result_t apply_pixel_cmd();
    pix_result_t res;
    int          b;
    int          x;
    int          y;
    res = '{rdata: 8'd0, status: ST_DONE};
    b   = int'(in_dst_buffer);
    x   = int'(in_dst_x);
    y   = int'(in_dst_y);
    case (action_t'(in_action))
      ACT_WRITE, ACT_READ: begin
        if (b >= NUM_BUFFERS || x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H)
          res.status = ST_OFF;
        else if (action_t'(in_action) == ACT_WRITE)
          frame_mem[pix_addr(b, x, y)] = in_pixel_value;
        else
          res.rdata = frame_mem[pix_addr(b, x, y)];
      end
      ACT_COPY: begin
        res.status = blit_rect(int'(in_src_buffer), int'(in_src_x), int'(in_src_y), b, x, y,
                               int'(in_copy_width), int'(in_copy_height), in_skip_zero);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    pix_result_t want;
    if (rst_n) begin
      // compare before predicting: a result never belongs to the item taken at this edge
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          flag_error("result with no item outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_read_data !== want.rdata)
            flag_error($sformatf("read_data got %0d want %0d", out_read_data, want.rdata));
          if (out_status !== want.status)
            flag_error($sformatf("status got %0d want %0d", out_status, want.status));
        end
        results_seen++;
      end
      if (start && !busy) pending_results.push_back(apply_pixel_cmd());
    end
  end

endmodule

// ----- tb/clipped_rect_blit_color_key_test.sv -----
`timescale 1ns / 1ps
module clipped_rect_blit_color_key_test;
  import crb_pkg::*;

  localparam int SW         = DEF_SCREEN_W;
  localparam int SH         = DEF_SCREEN_H;
  localparam int NB         = DEF_NUM_BUFFERS;
  localparam int N_RANDOM   = 1625;
  // the clearing pass after reset alone keeps the block quiet while it sweeps all NB*SW*SH pixels
  localparam int IDLE_LIMIT = 1_000_000;

  typedef struct {
    action_t            act;
    logic [2:0]         sbuf;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [2:0]         dbuf;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic               key;
    logic [7:0]         val;
  } blit_cmd_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_action;
  logic [2:0]         in_src_buffer;
  logic signed [15:0] in_src_x;
  logic signed [15:0] in_src_y;
  logic [2:0]         in_dst_buffer;
  logic signed [15:0] in_dst_x;
  logic signed [15:0] in_dst_y;
  logic signed [15:0] in_copy_width;
  logic signed [15:0] in_copy_height;
  logic               in_skip_zero;
  logic [7:0]         in_pixel_value;
  logic               out_valid;
  logic [7:0]         out_read_data;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 pending_count;
  bit                 gaps_on;

  clipped_rect_blit_color_key DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_src_buffer(in_src_buffer),
    .in_src_x(in_src_x), .in_src_y(in_src_y), .in_dst_buffer(in_dst_buffer),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y),
    .in_copy_width(in_copy_width), .in_copy_height(in_copy_height),
    .in_skip_zero(in_skip_zero), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_read_data(out_read_data), .out_status(out_status)
  );

  blit_checker u_blit_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_src_buffer(in_src_buffer),
    .in_src_x(in_src_x), .in_src_y(in_src_y), .in_dst_buffer(in_dst_buffer),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y),
    .in_copy_width(in_copy_width), .in_copy_height(in_copy_height),
    .in_skip_zero(in_skip_zero), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_read_data(out_read_data), .out_status(out_status),
    .errors(fail_count), .outstanding(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic blit_cmd_t pixel_cmd(action_t a, int b, int x, int y, int v);
    blit_cmd_t c;
    c = '{act: a, sbuf: 3'($urandom), sx: 16'($urandom), sy: 16'($urandom),
          dbuf: 3'(b), dx: 16'(x), dy: 16'(y), w: 16'($urandom), h: 16'($urandom),
          key: 1'($urandom), val: 8'(v)};
    return c;
  endfunction

  function automatic blit_cmd_t copy_cmd(int sb, int sx, int sy, int db, int dx, int dy,
                                         int w, int h, bit key);
    blit_cmd_t c;
    c = '{act: ACT_COPY, sbuf: 3'(sb), sx: 16'(sx), sy: 16'(sy), dbuf: 3'(db),
          dx: 16'(dx), dy: 16'(dy), w: 16'(w), h: 16'(h), key: key,
          val: 8'($urandom)};
    return c;
  endfunction

  // mostly a small hot corner so copies and reads meet written data; some near the edges
  function automatic int pick_coord(int lim);
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(31);
    if (r < 95) return $urandom_range(lim + 31) - 16;
    return lim - 1 - $urandom_range(15);
  endfunction

  function automatic int pick_buffer();
    if ($urandom_range(99) < 3) return $urandom_range(7);
    if ($urandom_range(99) < 70) return $urandom_range(1);
    return $urandom_range(NB - 1);
  endfunction

  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    int        r;
    int        sb;
    int        w;
    int        h;
    r = $urandom_range(99);
    if (r < 5) begin
      c = copy_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, 1'($urandom));
      c.act = action_t'($urandom_range(3));
      return c;
    end
    if (r < 62) begin
      // transparent pixels are common so the key has something to skip
      return pixel_cmd(r < 38 ? ACT_WRITE : ACT_READ, pick_buffer(), pick_coord(SW),
                       pick_coord(SH), $urandom_range(3) == 0 ? 0 : $urandom_range(255));
    end
    sb = pick_buffer();
    r  = $urandom_range(99);
    if (r < 86) begin
      w = $urandom_range(16);
      h = $urandom_range(16);
    end else if (r < 90) begin
      w = $urandom_range(280, 400);
      h = $urandom_range(4);
    end else if (r < 94) begin
      w = $urandom_range(4);
      h = $urandom_range(180, 260);
    end else if (r < 97) begin
      w = $urandom_range(16) - 8;
      h = $urandom_range(16) - 8;
    end else begin
      w = $urandom_range(64);
      h = $urandom_range(48);
    end
    return copy_cmd(sb, pick_coord(SW), pick_coord(SH),
                    $urandom_range(99) < 40 ? sb : pick_buffer(),
                    pick_coord(SW), pick_coord(SH), w, h, 1'($urandom));
  endfunction

  task automatic issue(blit_cmd_t c);
    if (gaps_on && $urandom_range(99) < 33) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_action      = c.act;
    in_src_buffer  = c.sbuf;
    in_src_x       = c.sx;
    in_src_y       = c.sy;
    in_dst_buffer  = c.dbuf;
    in_dst_x       = c.dx;
    in_dst_y       = c.dy;
    in_copy_width  = c.w;
    in_copy_height = c.h;
    in_skip_zero   = c.key;
    in_pixel_value = c.val;
    start          = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ACT_NONE;
    in_src_buffer  = '0;
    in_src_x       = '0;
    in_src_y       = '0;
    in_dst_buffer  = '0;
    in_dst_x       = '0;
    in_dst_y       = '0;
    in_copy_width  = '0;
    in_copy_height = '0;
    in_skip_zero   = 1'b0;
    in_pixel_value = '0;
    gaps_on        = 1'b1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    issue(pixel_cmd(ACT_WRITE, 0, 0, 0, 255));
    issue(pixel_cmd(ACT_WRITE, NB - 1, SW - 1, SH - 1, 8'hA5));
    issue(pixel_cmd(ACT_WRITE, 2, 3, 5, 7));
    issue(pixel_cmd(ACT_WRITE, 2, 5, 5, 8'h80));
    issue(pixel_cmd(ACT_READ, NB - 1, SW - 1, SH - 1, 0));
    issue(pixel_cmd(ACT_READ, 0, 0, 0, 0));
    // pixels off screen or in a missing buffer
    issue(pixel_cmd(ACT_WRITE, 0, -1, 0, 9));
    issue(pixel_cmd(ACT_READ, 0, SW, 0, 0));
    issue(pixel_cmd(ACT_READ, 1, 0, -32768, 0));
    issue(pixel_cmd(ACT_WRITE, 7, 1, 1, 3));
    issue(pixel_cmd(ACT_READ, NB, 0, 0, 0));
    issue(pixel_cmd(ACT_NONE, 7, 32767, -32768, 255));
    // overlapping copies within one buffer, keyed and plain, both directions
    issue(copy_cmd(2, 0, 5, 2, 1, 5, 12, 1, 1'b1));
    issue(copy_cmd(2, 0, 5, 2, 2, 5, 10, 2, 1'b0));
    issue(copy_cmd(2, 4, 5, 2, 0, 5, 10, 1, 1'b0));
    issue(copy_cmd(NB, 0, 0, 0, 0, 0, 4, 4, 1'b0));
    issue(copy_cmd(0, 0, 0, 7, 0, 0, 4, 4, 1'b0));
    issue(copy_cmd(0, SW, 0, 1, 0, 0, 4, 4, 1'b1));
    issue(copy_cmd(0, 0, 0, 1, 0, 0, SW, 4, 1'b0));
    issue(copy_cmd(0, 0, 0, 1, 0, 0, 4, SH, 1'b0));
    issue(copy_cmd(0, 0, 0, 1, 0, 0, 0, 5, 1'b0));
    issue(copy_cmd(0, 0, 0, 1, 0, 0, -1, 5, 1'b1));
    issue(copy_cmd(0, -5, -3, 3, 10, 10, 20, 8, 1'b0));
    issue(copy_cmd(2, 0, 0, 3, -2, -1, 32767, 3, 1'b0));
    issue(copy_cmd(2, 0, 0, 3, 0, 0, -32768, 32767, 1'b1));
    // largest legal rectangle
    issue(copy_cmd(NB - 1, 1, 1, 1, 0, 0, 32767, 32767, 1'b0));
    issue(pixel_cmd(ACT_READ, 1, SW - 2, SH - 2, 0));

    for (int n = 0; n < N_RANDOM; n++) begin
      gaps_on = !(n >= 600 && n < 900);
      issue(random_cmd());
    end
    start = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
